// File: rtl/tdss_pkg.sv
// ----------------------------------------------------------------------------
// tdss_pkg
// Shared types and constants of the table-driven step sequencer.
// ----------------------------------------------------------------------------
package tdss_pkg;

	localparam int MAX_STEPS = 16;
	localparam int MAX_RULES = 8;
	localparam int SLOT_W    = $clog2(MAX_STEPS);
	localparam int UCNT_W    = $clog2(MAX_STEPS + 1);
	localparam int RULE_W    = $clog2(MAX_RULES);
	localparam int RCNT_W    = $clog2(MAX_RULES + 1);
	localparam int RADDR_D   = MAX_STEPS * MAX_RULES;

	localparam logic [15:0] FALLBACK_ID = 16'h00FF;

	typedef enum logic [2:0] {
		ACT_LOAD_STEP = 3'd0,
		ACT_LOAD_RULE = 3'd1,
		ACT_START     = 3'd2,
		ACT_STOP      = 3'd3,
		ACT_RESET     = 3'd4,
		ACT_TICK      = 3'd5,
		ACT_OUTCOME   = 3'd6,
		ACT_NONE      = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		RUN_IDLE  = 2'd0,
		RUN_RUN   = 2'd1,
		RUN_ENDED = 2'd2,
		RUN_ERROR = 2'd3
	} run_t;

	localparam logic [1:0] RES_WAIT = 2'd0;
	localparam logic [1:0] RES_OK   = 2'd1;
	localparam logic [1:0] RES_ERR  = 2'd2;

	localparam logic [1:0] CFG_STEP_COUNT = 2'd0;
	localparam logic [1:0] CFG_CYCLE_MODE = 2'd1;
	localparam logic [1:0] CFG_END_STEP   = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_R0A,
		S_R0B,
		S_RCA,
		S_RCB,
		S_RSCAN,
		S_SSCAN
	} state_t;

	typedef enum logic [1:0] {
		SK_ERRTGT,
		SK_FALLBACK,
		SK_ENTER,
		SK_FINAL
	} search_t;

	typedef struct packed {
		logic [15:0]       id;
		logic [31:0]       timeout;
		logic [RCNT_W-1:0] rule_count;
		logic              has_handler;
	} step_ent_t;

	typedef struct packed {
		logic [1:0]  result;
		logic [15:0] target;
	} rule_ent_t;

endpackage

// File: rtl/tdss_ram.sv
// ----------------------------------------------------------------------------
// tdss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/table_driven_step_sequencer_top.sv
// ----------------------------------------------------------------------------
// table_driven_step_sequencer_top
// Step sequencer over a loaded table of steps with timeouts and result rules.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive action and its fields with start high; the word is
//   taken at an edge where busy is low. busy stays high until the result.
//   Result: done pulses for one cycle with machine_state, current_step_id and
//   step_found; the receiver cannot stall, so it must sample on done.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always
//   ready, write only while busy is low.
//   Sequencing: loads, start, stop take one scan of the step table. Tick and
//   outcome add a table read, a rule scan and up to two more table scans. The
//   step table RAM read port sets the pace: one entry per cycle during every
//   scan.
//   Reset: control clears at once; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module table_driven_step_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [3:0]  entry_index,
	input  logic [2:0]  rule_index,
	input  logic [15:0] step_id,
	input  logic [31:0] timeout_ticks,
	input  logic [3:0]  rule_count,
	input  logic        has_handler,
	input  logic [1:0]  rule_result,
	input  logic [15:0] next_step_id,
	input  logic [1:0]  step_outcome,
	output logic        done,
	output logic [1:0]  machine_state,
	output logic [15:0] current_step_id,
	output logic        step_found,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tdss_pkg::*;

	state_t state_q, state_d;
	search_t purp_q, purp_d;
	action_t act_q, act_d;
	run_t run_q, run_d;
	logic [15:0] cur_id_q, cur_id_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic slot_valid_q, slot_valid_d;
	logic [31:0] start_time_q, start_time_d, time_q, time_d;
	logic [1:0] oc_q, oc_d;
	logic [4:0] step_count_q;
	logic cycle_mode_q;
	logic [15:0] end_id_q;
	logic [RCNT_W-1:0] rc_q, rc_d, ri_q, ri_d;
	logic [UCNT_W-1:0] si_q, si_d;
	logic v_s1, v_d;
	logic [SLOT_W-1:0] slot_s1, slot_s1_d;
	logic [1:0] rkey_q, rkey_d;
	logic [15:0] skey_q, skey_d;
	logic done_q, done_d, found_q, found_d;

	logic [UCNT_W-1:0] used;
	logic cur_ok, accept;
	logic s_we, r_we;
	logic [SLOT_W-1:0] s_raddr;
	step_ent_t s_wdata, s_rdata;
	rule_ent_t r_wdata, r_rdata;
	logic [SLOT_W+RULE_W-1:0] r_waddr;
	logic [RCNT_W-1:0] rc_clamp;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign used      = (step_count_q > 5'(MAX_STEPS)) ? UCNT_W'(MAX_STEPS)
	                                                  : UCNT_W'(step_count_q);
	assign cur_ok    = slot_valid_q && (UCNT_W'(slot_q) < used);
	assign rc_clamp  = (rule_count > 4'(MAX_RULES)) ? RCNT_W'(MAX_RULES)
	                                                : RCNT_W'(rule_count);

	assign s_we    = accept && (action_t'(action) == ACT_LOAD_STEP)
	                 && (int'(entry_index) < MAX_STEPS);
	assign r_we    = accept && (action_t'(action) == ACT_LOAD_RULE)
	                 && (int'(entry_index) < MAX_STEPS) && (int'(rule_index) < MAX_RULES);
	assign s_wdata = '{id: step_id, timeout: timeout_ticks, rule_count: rc_clamp,
	                   has_handler: has_handler};
	assign r_wdata = '{result: rule_result, target: next_step_id};
	assign r_waddr = {SLOT_W'(entry_index), RULE_W'(rule_index)};

	always_comb begin
		case (state_q)
			S_R0A:   s_raddr = '0;
			S_RCA:   s_raddr = slot_q;
			default: s_raddr = si_q[SLOT_W-1:0];
		endcase
	end

	tdss_ram #(.WIDTH($bits(step_ent_t)), .DEPTH(MAX_STEPS)) u_step_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (SLOT_W'(entry_index)),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	tdss_ram #(.WIDTH($bits(rule_ent_t)), .DEPTH(RADDR_D)) u_rule_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.raddr ({slot_q, ri_q[RULE_W-1:0]}),
		.rdata (r_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= '0;
			cycle_mode_q <= 1'b0;
			end_id_q     <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STEP_COUNT: step_count_q <= cfg_data[4:0];
				CFG_CYCLE_MODE: cycle_mode_q <= cfg_data[0];
				CFG_END_STEP:   end_id_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			run_q        <= RUN_IDLE;
			cur_id_q     <= '0;
			slot_q       <= '0;
			slot_valid_q <= 1'b1;
			start_time_q <= '0;
			time_q       <= '0;
			done_q       <= 1'b0;
			v_s1         <= 1'b0;
		end else begin
			state_q      <= state_d;
			run_q        <= run_d;
			cur_id_q     <= cur_id_d;
			slot_q       <= slot_d;
			slot_valid_q <= slot_valid_d;
			start_time_q <= start_time_d;
			time_q       <= time_d;
			done_q       <= done_d;
			v_s1         <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		purp_q   <= purp_d;
		act_q    <= act_d;
		oc_q     <= oc_d;
		rc_q     <= rc_d;
		ri_q     <= ri_d;
		si_q     <= si_d;
		slot_s1  <= slot_s1_d;
		rkey_q   <= rkey_d;
		skey_q   <= skey_d;
		found_q  <= found_d;
	end

	always_comb begin
		state_d      = state_q;
		purp_d       = purp_q;
		act_d        = act_q;
		run_d        = run_q;
		cur_id_d     = cur_id_q;
		slot_d       = slot_q;
		slot_valid_d = slot_valid_q;
		start_time_d = start_time_q;
		time_d       = time_q;
		oc_d         = oc_q;
		rc_d         = rc_q;
		ri_d         = ri_q;
		si_d         = si_q;
		v_d          = 1'b0;
		slot_s1_d    = slot_s1;
		rkey_d       = rkey_q;
		skey_d       = skey_q;
		found_d      = found_q;
		done_d       = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					act_d   = action_t'(action);
					oc_d    = step_outcome;
					state_d = S_SSCAN;
					purp_d  = SK_FINAL;
					skey_d  = cur_id_q;
					si_d    = '0;
					case (action_t'(action))
						ACT_LOAD_STEP: begin
							if (s_we && (entry_index == '0)) begin
								cur_id_d     = step_id;
								slot_d       = '0;
								slot_valid_d = 1'b1;
								skey_d       = step_id;
							end
						end
						ACT_START: begin
							if (run_q == RUN_IDLE || run_q == RUN_ENDED) begin
								run_d        = RUN_RUN;
								start_time_d = time_q;
							end
						end
						ACT_STOP: run_d = RUN_IDLE;
						ACT_RESET: state_d = S_R0A;
						ACT_TICK: begin
							time_d = time_q + 32'd1;
							if (run_q == RUN_RUN) begin
								if (cur_ok) state_d = S_RCA;
								else run_d = RUN_ERROR;
							end
						end
						ACT_OUTCOME: begin
							if (run_q == RUN_RUN) begin
								if (cur_ok) state_d = S_RCA;
								else run_d = RUN_ERROR;
							end
						end
						default: ;
					endcase
				end
			end
			S_R0A: state_d = S_R0B;
			S_R0B: begin
				si_d   = '0;
				skey_d = s_rdata.id;
				state_d = S_SSCAN;
				if (act_q == ACT_RESET) begin
					run_d        = RUN_IDLE;
					cur_id_d     = s_rdata.id;
					slot_d       = '0;
					slot_valid_d = 1'b1;
					start_time_d = '0;
					purp_d       = SK_FINAL;
				end else begin
					run_d  = RUN_RUN;
					purp_d = SK_ENTER;
				end
			end
			S_RCA: state_d = S_RCB;
			S_RCB: begin
				rc_d    = s_rdata.rule_count;
				ri_d    = '0;
				purp_d  = SK_FINAL;
				skey_d  = cur_id_q;
				si_d    = '0;
				state_d = S_SSCAN;
				if (act_q == ACT_TICK) begin
					if ((s_rdata.timeout != '0)
					    && ((time_q - start_time_q) >= s_rdata.timeout)) begin
						rkey_d  = RES_ERR;
						state_d = S_RSCAN;
					end
				end else if (!s_rdata.has_handler) begin
					run_d = RUN_ERROR;
				end else if (oc_q == RES_OK) begin
					rkey_d  = RES_OK;
					state_d = S_RSCAN;
				end else if (oc_q != RES_WAIT) begin
					rkey_d  = RES_ERR;
					state_d = S_RSCAN;
				end
			end
			S_RSCAN: begin
				if (ri_q < rc_q) begin
					v_d        = 1'b1;
					ri_d       = ri_q + RCNT_W'(1);
				end
				if ((v_s1 && (r_rdata.result == rkey_q)) || (!v_s1 && (ri_q >= rc_q))) begin
					v_d     = 1'b0;
					si_d    = '0;
					state_d = S_SSCAN;
					purp_d  = SK_FINAL;
					skey_d  = cur_id_q;
					if (v_s1) begin
						if (rkey_q == RES_ERR) begin
							skey_d = r_rdata.target;
							purp_d = SK_ERRTGT;
						end else if (r_rdata.target == end_id_q) begin
							run_d = RUN_ENDED;
							if (cycle_mode_q) state_d = S_R0A;
						end else begin
							skey_d = r_rdata.target;
							purp_d = SK_ENTER;
						end
					end else if (rkey_q == RES_ERR) begin
						skey_d = FALLBACK_ID;
						purp_d = SK_FALLBACK;
					end else begin
						run_d = RUN_ERROR;
					end
				end
			end
			S_SSCAN: begin
				if (si_q < used) begin
					v_d       = 1'b1;
					slot_s1_d = si_q[SLOT_W-1:0];
					si_d      = si_q + UCNT_W'(1);
				end
				if ((v_s1 && (s_rdata.id == skey_q)) || (!v_s1 && (si_q >= used))) begin
					v_d  = 1'b0;
					si_d = '0;
					case (purp_q)
						SK_FINAL: begin
							found_d = v_s1;
							done_d  = 1'b1;
							state_d = S_IDLE;
						end
						SK_ERRTGT, SK_FALLBACK: begin
							if (v_s1) begin
								cur_id_d     = skey_q;
								slot_d       = slot_s1;
								slot_valid_d = 1'b1;
								start_time_d = time_q;
								purp_d       = SK_FINAL;
							end else if (purp_q == SK_ERRTGT) begin
								skey_d = FALLBACK_ID;
								purp_d = SK_FALLBACK;
							end else begin
								run_d  = RUN_ERROR;
								skey_d = cur_id_q;
								purp_d = SK_FINAL;
							end
						end
						default: begin
							cur_id_d     = skey_q;
							slot_d       = v_s1 ? slot_s1 : '0;
							slot_valid_d = v_s1;
							start_time_d = time_q;
							purp_d       = SK_FINAL;
						end
					endcase
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign done            = done_q;
	assign machine_state   = run_q;
	assign current_step_id = cur_id_q;
	assign step_found      = found_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a command in progress");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("command accepted but block not busy");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while still busy");
endmodule
